[hdl/tsrr_pkg.sv]
// Package for the round robin / fixed priority task scheduler: codes, types, defaults.
`default_nettype none
package tsrr_pkg;

  localparam int TASKS_DEF      = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int CODE_W   = 8;
  localparam int OUT_CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_YIELD   = 2'd1,
    CMD_WAKE    = 2'd2,
    CMD_SUSPEND = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCHED_MODE   = 3'd0,
    REG_SUSPEND_EN   = 3'd1,
    REG_INIT_STATE_EN = 3'd2,
    REG_INIT_MASK    = 3'd3,
    REG_COUNT_EN     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic decide;
    logic commit;
  } sched_ctl_t;

endpackage
`default_nettype wire

[hdl/tsrr_ctrl.sv]
// Sequencer for the task scheduler: capture, status update, decision, commit.
`default_nettype none
module tsrr_ctrl
  import tsrr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  output sched_ctl_t      ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        ctl.decide = 1'b1;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/tsrr_dpath.sv]
// Datapath for the task scheduler: registers, ready vector, selection and counts.
`default_nettype none
module tsrr_dpath
  import tsrr_pkg::*;
#(
  parameter int TASKS      = TASKS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sched_ctl_t            ctl,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [IDX_W-1:0]      in_task_index,
  input  wire logic                  in_use_hint,
  input  wire logic [CODE_W-1:0]     in_hold_code,
  input  wire logic                  in_from_isr,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_next_task,
  output logic                       out_selected,
  output logic                       out_swap_now,
  output logic                       out_none_ready,
  output logic [OUT_CNT_W-1:0]       out_sched_count
);

  localparam int TW = $clog2(TASKS);

  function automatic logic [TW:0] find_first(input logic [TASKS-1:0] v);
    logic [TW:0] r;
    r = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, TW'(i)};
    end
    return r;
  endfunction

  logic                  mode_r, susp_en_r, init_en_r, cnt_en_r;
  logic [CFG_DATA_W-1:0] mask_r;

  cmd_t              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic              hint_r, isr_r;
  logic [CODE_W-1:0] code_r;

  logic [TASKS-1:0]      ready_r;
  logic [TW-1:0]         active_r;
  logic [COUNT_BITS-1:0] count_r [TASKS];

  logic [TW-1:0] pick_r;
  logic          sel_r, swap_r, none_r;

  logic          sel_nxt, swap_nxt, none_nxt;
  logic [TW-1:0] pick_nxt;

  logic             idx_ok;
  logic [TW-1:0]    idx_t;
  logic [TASKS-1:0] eff_ready, above;
  logic [TW:0]      low_ff, hi_ff;

  assign idx_ok = ({1'b0, idx_r} < 5'(TASKS));
  assign idx_t  = idx_r[TW-1:0];

  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      eff_ready[i] = ready_r[i] || !susp_en_r;
      above[i]     = (TW'(i) > active_r);
    end
  end

  assign low_ff = find_first(eff_ready);
  assign hi_ff  = find_first(eff_ready & above);

  always_comb begin
    logic          resched, has_hint;
    logic [TW:0]   rr;
    resched  = 1'b0;
    has_hint = 1'b0;
    sel_nxt  = 1'b0;
    swap_nxt = 1'b0;
    none_nxt = 1'b0;
    pick_nxt = active_r;
    rr       = hi_ff[TW] ? hi_ff : low_ff;
    unique case (cmd_r)
      CMD_START: begin
        if (!init_en_r) begin
          sel_nxt  = 1'b1;
          pick_nxt = '0;
        end else begin
          sel_nxt  = low_ff[TW];
          pick_nxt = low_ff[TW-1:0];
        end
        none_nxt = !sel_nxt;
        swap_nxt = sel_nxt;
      end
      CMD_YIELD: begin
        resched  = 1'b1;
        has_hint = mode_r && hint_r;
      end
      CMD_WAKE: begin
        resched  = susp_en_r && idx_ok && mode_r;
        has_hint = 1'b1;
      end
      CMD_SUSPEND: begin
        resched = susp_en_r && idx_ok && (idx_t == active_r);
      end
      default: ;
    endcase
    if (resched) begin
      priority if (!mode_r) begin
        sel_nxt  = rr[TW];
        pick_nxt = rr[TW-1:0];
        none_nxt = !rr[TW];
      end else if (has_hint) begin
        sel_nxt  = idx_ok && !(idx_r > 4'(active_r));
        pick_nxt = idx_t;
      end else begin
        sel_nxt  = low_ff[TW];
        pick_nxt = low_ff[TW-1:0];
        none_nxt = !low_ff[TW];
      end
      swap_nxt = sel_nxt && !isr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      susp_en_r <= 1'b1;
      init_en_r <= 1'b1;
      mask_r    <= '1;
      cnt_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCHED_MODE:    mode_r    <= cfg_wdata[0];
        REG_SUSPEND_EN:    susp_en_r <= cfg_wdata[0];
        REG_INIT_STATE_EN: init_en_r <= cfg_wdata[0];
        REG_INIT_MASK:     mask_r    <= cfg_wdata;
        REG_COUNT_EN:      cnt_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      idx_r  <= in_task_index;
      hint_r <= in_use_hint;
      code_r <= in_hold_code;
      isr_r  <= in_from_isr;
    end
    if (ctl.decide) begin
      pick_r <= pick_nxt;
      sel_r  <= sel_nxt;
      swap_r <= swap_nxt;
      none_r <= none_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= '1;
      active_r <= '0;
      for (int i = 0; i < TASKS; i++) count_r[i] <= '0;
    end else begin
      if (ctl.update) begin
        if (cmd_r == CMD_START) begin
          ready_r <= mask_r[TASKS-1:0];
        end else if (cmd_r == CMD_WAKE && susp_en_r && idx_ok) begin
          ready_r[idx_t] <= 1'b1;
        end else if (cmd_r == CMD_SUSPEND && susp_en_r && idx_ok) begin
          ready_r[idx_t] <= (code_r == '0);
        end
      end
      if (ctl.commit && sel_r) begin
        active_r <= pick_r;
        if (cnt_en_r) count_r[pick_r] <= count_r[pick_r] + 1'b1;
      end
    end
  end

  logic [TW-1:0]         res_task;
  logic [COUNT_BITS-1:0] res_count;

  assign res_task  = sel_r ? pick_r : active_r;
  assign res_count = count_r[res_task] + COUNT_BITS'(sel_r && cnt_en_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_next_task   <= 4'(res_task);
      out_selected    <= sel_r;
      out_swap_now    <= swap_r;
      out_none_ready  <= none_r;
      out_sched_count <= OUT_CNT_W'(res_count);
    end
  end

endmodule
`default_nettype wire

[hdl/task_scheduler_rr_priority.sv]
// Top level of the round robin / fixed priority task scheduler.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | start, busy          | cmd, task_index, use_hint, hold_code,
//            |                      | from_isr
//   out      | out_valid (1 cycle)  | next_task, selected, swap_now,
//            |                      | none_ready, sched_count
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// Each item passes capture, status update, decision over the ready vector and
// commit of count and active task; out_valid is registered from commit. busy
// drops in the strobe cycle; a new item is taken only when the last is through.
// Reset sets all tasks ready, active task 0, counts 0, registers to defaults.
// Results cannot be stalled; out_valid is high for one cycle per item.
`default_nettype none
module task_scheduler_rr_priority
  import tsrr_pkg::*;
#(
  parameter int TASKS      = TASKS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [IDX_W-1:0]      in_task_index,
  input  wire logic                  in_use_hint,
  input  wire logic [CODE_W-1:0]     in_hold_code,
  input  wire logic                  in_from_isr,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_next_task,
  output logic                       out_selected,
  output logic                       out_swap_now,
  output logic                       out_none_ready,
  output logic [OUT_CNT_W-1:0]       out_sched_count,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  sched_ctl_t ctl;

  tsrr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  tsrr_dpath #(
    .TASKS      (TASKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_task_index   (in_task_index),
    .in_use_hint     (in_use_hint),
    .in_hold_code    (in_hold_code),
    .in_from_isr     (in_from_isr),
    .out_valid       (out_valid),
    .out_next_task   (out_next_task),
    .out_selected    (out_selected),
    .out_swap_now    (out_swap_now),
    .out_none_ready  (out_none_ready),
    .out_sched_count (out_sched_count)
  );

endmodule
`default_nettype wire
